>>> hdl/itcf_pkg.sv
// Shared types, constants and helper functions for the tilt complementary filter.
`default_nettype none
package itcf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES);
  localparam int XY_W         = 34;
  localparam int Z_W          = 28;

  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [16:0]           ONE_Q16     = 17'd65536;

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // atan(2^-i) in Q.24
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [39:0] v);
    if (v > 40'sd131071) return 18'sh1FFFF;
    if (v < -40'sd131072) return 18'sh20000;
    return v[17:0];
  endfunction

  function automatic logic signed [18:0] sat19(input logic signed [39:0] v);
    if (v > 40'sd262143) return 19'sh3FFFF;
    if (v < -40'sd262144) return 19'sh40000;
    return v[18:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/itcf_cordic_cell.sv
// One vectoring CORDIC iteration, registered, for the cell chain.
`default_nettype none
module itcf_cordic_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [itcf_pkg::STEP_W-1:0] step_idx,
  input  wire itcf_pkg::cordic_t          cell_in,
  output itcf_pkg::cordic_t               cell_out
);
  import itcf_pkg::*;

  cordic_t                cell_r;
  cordic_t                cell_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  ang;

  always_comb begin
    dx  = cell_in.y >>> step_idx;
    dy  = cell_in.x >>> step_idx;
    ang = atan_lut(step_idx);
    cell_nxt.valid = cell_in.valid;
    if (!cell_in.y[XY_W-1]) begin
      cell_nxt.x = cell_in.x + dx;
      cell_nxt.y = cell_in.y - dy;
      cell_nxt.z = cell_in.z + ang;
    end else begin
      cell_nxt.x = cell_in.x - dx;
      cell_nxt.y = cell_in.y + dy;
      cell_nxt.z = cell_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.x <= cell_nxt.x;
    cell_r.y <= cell_nxt.y;
    cell_r.z <= cell_nxt.z;
  end

  assign cell_out = cell_r;

endmodule
`default_nettype wire

>>> hdl/imu_tilt_complementary_filter.sv
// Top level: IMU tilt complementary filter with a CORDIC cell chain and blend sequencer.
// A valid sample's result waits for the CORDIC cell chain; a failed read goes straight to
// the output register. One sample at a time: no new input is taken until the result has
// been handed to the output register.
// Synchronous active-low reset clears control, filter state, failure count and registers
// to their reset values (blend 64225, smoothing 6554, biases 0).
`default_nettype none
module imu_tilt_complementary_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // accel_x[15:0], accel_z[31:16], pitch_rate_in[50:32], yaw_rate_in[69:51],
  // time_step[85:70], zero pad
  input  wire logic [87:0] in_tdata,
  // sample_valid
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tilt_angle[17:0], accel_tilt[35:18], pitch_rate_out[54:36], smoothed_yaw[73:55],
  // failure_count[89:74], zero pad
  output logic [95:0]      out_tdata,
  // imu_ok
  output logic             out_tuser,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [18:0] cfg_wdata
);
  import itcf_pkg::*;

  localparam logic [1:0] REG_PITCH_BIAS = 2'd0;
  localparam logic [1:0] REG_YAW_BIAS   = 2'd1;
  localparam logic [1:0] REG_BLEND      = 2'd2;
  localparam logic [1:0] REG_SMOOTH     = 2'd3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_YAW1 = 4'd1;
  localparam logic [3:0] S_YAW2 = 4'd2;
  localparam logic [3:0] S_PIT1 = 4'd3;
  localparam logic [3:0] S_PIT2 = 4'd4;
  localparam logic [3:0] S_WAIT = 4'd5;
  localparam logic [3:0] S_TIL1 = 4'd6;
  localparam logic [3:0] S_TIL2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // configuration registers
  logic signed [18:0] pbias_r, ybias_r;
  logic [16:0]        blend_r, smooth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbias_r  <= '0;
      ybias_r  <= '0;
      blend_r  <= 17'd64225;
      smooth_r <= 17'd6554;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PITCH_BIAS: pbias_r  <= cfg_wdata;
        REG_YAW_BIAS:   ybias_r  <= cfg_wdata;
        REG_BLEND:      blend_r  <= cfg_wdata[16:0];
        REG_SMOOTH:     smooth_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // input field unpacking
  logic signed [15:0] ax, az;
  logic signed [18:0] prate, yrate;
  logic [15:0]        dt_in;
  assign ax    = in_tdata[15:0];
  assign az    = in_tdata[31:16];
  assign prate = in_tdata[50:32];
  assign yrate = in_tdata[69:51];
  assign dt_in = in_tdata[85:70];

  logic [3:0] state_r;
  logic       in_xfer;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // pre-rotation into the right half plane, inputs scaled by 2^14
  cordic_t                seed;
  logic signed [XY_W-1:0] xs, ys;
  always_comb begin
    xs = XY_W'(ax) <<< 14;
    ys = XY_W'(az) <<< 14;
    seed.valid = in_xfer && in_tuser;
    if (xs[XY_W-1]) begin
      if (!ys[XY_W-1]) begin
        seed.x = ys;
        seed.y = -xs;
        seed.z = HALF_PI_Q24;
      end else begin
        seed.x = -ys;
        seed.y = xs;
        seed.z = -HALF_PI_Q24;
      end
    end else begin
      seed.x = xs;
      seed.y = ys;
      seed.z = '0;
    end
  end

  // cell chain: link[0] is the seed register, each cell registers the next link
  cordic_t link [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link[0].valid <= 1'b0;
    end else begin
      link[0].valid <= seed.valid;
    end
    link[0].x <= seed.x;
    link[0].y <= seed.y;
    link[0].z <= seed.z;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    itcf_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (STEP_W'(g)),
      .cell_in  (link[g]),
      .cell_out (link[g+1])
    );
  end

  // datapath registers
  logic signed [18:0] rate_r, ryaw_r;
  logic [16:0]        c_r, a_r;
  logic [15:0]        dt_r;
  logic               zero_r, ok_r;
  logic signed [39:0] prod_r;
  logic signed [20:0] gyro_r;
  logic signed [17:0] acc_r;
  logic signed [17:0] tilt_r;
  logic signed [18:0] yaw_r;
  logic [15:0]        fail_r;

  // combinational helpers
  logic signed [19:0] rate_diff;
  logic signed [20:0] yaw_diff;
  logic signed [35:0] mul_ay, mul_ry, mul_rd, mul_ca;
  logic signed [38:0] mul_cg;
  logic signed [39:0] sum_w, rnd_w;
  logic signed [Z_W-1:0] z_rnd;
  logic [16:0]        one_minus_a, one_minus_c;

  always_comb begin
    rate_diff   = 20'(prate) - 20'(pbias_r);
    yaw_diff    = 21'(ybias_r) - 21'(yrate);
    one_minus_a = ONE_Q16 - a_r;
    one_minus_c = ONE_Q16 - c_r;
    mul_ay      = $signed({1'b0, a_r}) * ryaw_r;
    mul_ry      = $signed({1'b0, one_minus_a}) * yaw_r;
    mul_rd      = rate_r * $signed({1'b0, dt_r});
    mul_cg      = $signed({1'b0, c_r}) * gyro_r;
    mul_ca      = $signed({1'b0, one_minus_c}) * acc_r;
    // second term only in the blend states; the gyro increment rounds prod_r alone
    if (state_r == S_YAW2) begin
      sum_w = prod_r + 40'(mul_ry);
    end else if (state_r == S_TIL2) begin
      sum_w = prod_r + 40'(mul_ca);
    end else begin
      sum_w = prod_r;
    end
    rnd_w       = (sum_w + 40'sd32768) >>> 16;
    z_rnd       = (link[CORDIC_STEPS].z + 28'sd256) >>> 9;
  end

  // sequencer: yaw EMA and gyro increment run while the chain works
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tilt_r  <= '0;
      yaw_r   <= '0;
      fail_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_xfer) begin
          if (in_tuser) begin
            state_r <= S_YAW1;
          end else begin
            state_r <= S_DONE;
            if (fail_r != 16'hFFFF) fail_r <= fail_r + 16'd1;
          end
        end
        S_YAW1: state_r <= S_YAW2;
        S_YAW2: begin
          yaw_r   <= sat19(rnd_w);
          state_r <= S_PIT1;
        end
        S_PIT1: state_r <= S_PIT2;
        S_PIT2: state_r <= S_WAIT;
        S_WAIT: if (link[CORDIC_STEPS].valid) state_r <= S_TIL1;
        S_TIL1: state_r <= S_TIL2;
        S_TIL2: begin
          tilt_r  <= sat18(rnd_w);
          state_r <= S_DONE;
        end
        S_DONE: if (!out_tvalid || out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload side of the sequencer
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_xfer) begin
        ok_r   <= in_tuser;
        zero_r <= (ax == 16'sd0) && (az == 16'sd0);
        dt_r   <= dt_in;
        c_r    <= (blend_r > ONE_Q16) ? ONE_Q16 : blend_r;
        a_r    <= (smooth_r > ONE_Q16) ? ONE_Q16 : smooth_r;
        ryaw_r <= sat19(40'(yaw_diff));
        if (in_tuser) begin
          rate_r <= sat19(40'(rate_diff));
        end else begin
          rate_r <= '0;
          acc_r  <= '0;
        end
      end
      S_YAW1: prod_r <= 40'(mul_ay);
      S_PIT1: prod_r <= 40'(mul_rd);
      S_PIT2: gyro_r <= 21'(tilt_r) + rnd_w[20:0];
      S_WAIT: if (link[CORDIC_STEPS].valid) begin
        acc_r <= zero_r ? 18'sd0 : sat18(40'(z_rnd));
      end
      S_TIL1: prod_r <= 40'(mul_cg);
      default: ;
    endcase
  end

  // output register: one result held until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (state_r == S_DONE && (!out_tvalid || out_tready)) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
    if (state_r == S_DONE && (!out_tvalid || out_tready)) begin
      out_tuser <= ok_r;
      out_tdata <= {6'd0, fail_r, yaw_r, rate_r, acc_r, tilt_r};
    end
  end

endmodule
`default_nettype wire
